@@ hdl/lge_pkg.sv @@
// Shared types and constants for the toroidal life grid engine.
`default_nettype none

package lge_pkg;

   // Default grid edge length in cells
   localparam int GRID_SIZE_DEF = 32;

   // Item field widths
   localparam int CMD_W      = 2;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 5;
   localparam int ROW_BITS_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   // Neighbor counts of the life rule
   localparam logic [3:0] KEEP_COUNT  = 4'd2;
   localparam logic [3:0] BIRTH_COUNT = 4'd3;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_STEP   = 2'd0,
      CMD_TOGGLE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP_A,
      ST_STEP_B,
      ST_STEP_C,
      ST_RUN,
      ST_LAST,
      ST_RD,
      ST_MOD,
      ST_REPLY
   } state_type;

endpackage

`default_nettype wire

@@ hdl/life_grid_engine.sv @@
// Top level of the toroidal life grid engine: controller, grid memory, result register.
`default_nettype none

// The grid of GRID_SIZE x GRID_SIZE cells lives in one synchronous memory, one row per
// entry, with a valid flag per row so reset and the clear command empty the grid at once.
// Every command gives one result item holding the addressed row (columns 0..31) and the
// addressed cell as they stand after the command. Toggle, clear and read pass through a
// read, a modify and a reply state. For a step the single read port first sweeps the rows
// one per cycle through a three-row window, writing each new row behind the sweep, then
// the addressed row is read back. One item is worked on at a time; a finished result
// waits in the output register while the next item is taken in.
module life_grid_engine
   import lge_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [REQ_DATA_W-1:0] req_tdata,   // command[1:0], row[6:2], col[11:7]
   // result channel
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // row_bits[31:0], cell_alive[32]
);

   localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
   localparam logic [6:0] GS_EXT = 7'(GRID_SIZE);
   localparam logic [AW-1:0] LAST_ROW = AW'(GRID_SIZE - 1);

   // Controller state and latched command
   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_ff;
   logic [AW-1:0]      rd_ff, rd_in;

   // Grid memory and row valid flags
   logic [GRID_SIZE-1:0] grid_mem [GRID_SIZE];
   logic [GRID_SIZE-1:0] rdq_ff;
   logic                 rvld_ff;
   logic [GRID_SIZE-1:0] vld_ff;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 mem_we;
   logic [GRID_SIZE-1:0] wr_data;
   logic [GRID_SIZE-1:0] rd_data;

   // Row window for the generation sweep
   logic [GRID_SIZE-1:0] prev_ff, cur_ff, first_ff;
   logic [GRID_SIZE-1:0] dn_row, nxt_row;

   // Result staging
   logic [ROW_BITS_W-1:0] res_bits_ff, res_bits_in;
   logic                  res_cell_ff, res_cell_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Strobes from the controller
   logic req_accept, clr_all, ld_prev, ld_head, ld_win, ld_res, ld_rsp;

   // Address decode of the latched item
   logic                 row_ok, col_ok;
   logic [AW-1:0]        row_a, col_a;
   logic [GRID_SIZE-1:0] tog_mask, new_row;
   logic [63:0]          row64;

   assign row_ok = {2'b00, row_ff} < GS_EXT;
   assign col_ok = {2'b00, col_ff} < GS_EXT;
   assign row_a  = row_ok ? AW'({2'b00, row_ff}) : '0;
   assign col_a  = col_ok ? AW'({2'b00, col_ff}) : '0;

   // Rows never written since reset or clear read as dead
   assign rd_data = rvld_ff ? rdq_ff : '0;

   // Bottom neighbor: next row from memory, or saved old row 0 at the wrap
   assign dn_row = (state_ff == ST_LAST) ? first_ff : rd_data;

   lge_row_rule #(
      .GRID_SIZE (GRID_SIZE)
   ) u_rule (
      .up_row  (prev_ff),
      .mid_row (cur_ff),
      .dn_row  (dn_row),
      .nxt_row (nxt_row)
   );

   // Apply a toggle to the addressed row and form the result fields
   always_comb begin
      tog_mask        = '0;
      tog_mask[col_a] = 1'b1;
      if ((cmd_ff == CMD_TOGGLE) && row_ok && col_ok) begin
         new_row = rd_data ^ tog_mask;
      end else begin
         new_row = rd_data;
      end
      row64       = row_ok ? 64'(new_row) : 64'd0;
      res_bits_in = row64[ROW_BITS_W-1:0];
      res_cell_in = row_ok && col_ok && row64[{1'b0, col_ff}];
   end

   // Next state and strobes
   always_comb begin
      state_in   = state_ff;
      rd_in      = rd_ff;
      req_tready = 1'b0;
      rd_addr    = '0;
      wr_addr    = '0;
      wr_data    = nxt_row;
      mem_we     = 1'b0;
      clr_all    = 1'b0;
      ld_prev    = 1'b0;
      ld_head    = 1'b0;
      ld_win     = 1'b0;
      ld_res     = 1'b0;
      ld_rsp     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               case (cmd_type'(req_tdata[CMD_W-1:0]))
                  CMD_STEP:  state_in = ST_STEP_A;
                  CMD_CLEAR: begin
                     clr_all  = 1'b1;
                     state_in = ST_RD;
                  end
                  default:   state_in = ST_RD;
               endcase
            end
         end
         ST_STEP_A: begin
            rd_addr  = LAST_ROW;
            state_in = ST_STEP_B;
         end
         ST_STEP_B: begin
            rd_addr  = '0;
            ld_prev  = 1'b1;
            state_in = ST_STEP_C;
         end
         ST_STEP_C: begin
            rd_addr  = AW'(1);
            ld_head  = 1'b1;
            rd_in    = AW'(1);
            state_in = ST_RUN;
         end
         ST_RUN: begin
            // row rd_ff arrives; write new row rd_ff-1, fetch rd_ff+1
            rd_addr = (rd_ff == LAST_ROW) ? '0 : rd_ff + AW'(1);
            wr_addr = rd_ff - AW'(1);
            mem_we  = 1'b1;
            ld_win  = 1'b1;
            rd_in   = rd_ff + AW'(1);
            if (rd_ff == LAST_ROW) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            wr_addr  = LAST_ROW;
            mem_we   = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            rd_addr  = row_a;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            wr_addr  = row_a;
            wr_data  = new_row;
            mem_we   = (cmd_ff == CMD_TOGGLE) && row_ok && col_ok;
            ld_res   = 1'b1;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ld_rsp   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   // Hold controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the command and sweep position
   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      if (req_accept) begin
         cmd_ff <= cmd_type'(req_tdata[CMD_W-1:0]);
         row_ff <= req_tdata[CMD_W +: ROW_W];
         col_ff <= req_tdata[CMD_W+ROW_W +: COL_W];
      end
   end

   // Grid memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[wr_addr] <= wr_data;
      end
      rdq_ff <= grid_mem[rd_addr];
   end

   // Row valid flags: drop all on reset or clear, set on write
   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[wr_addr] <= 1'b1;
      end
      rvld_ff <= vld_ff[rd_addr];
   end

   // Advance the three-row window
   always_ff @(posedge clock) begin
      if (ld_prev) begin
         prev_ff <= rd_data;
      end
      if (ld_head) begin
         cur_ff   <= rd_data;
         first_ff <= rd_data;
      end
      if (ld_win) begin
         prev_ff <= cur_ff;
         cur_ff  <= rd_data;
      end
   end

   // Stage the result
   always_ff @(posedge clock) begin
      if (ld_res) begin
         res_bits_ff <= res_bits_in;
         res_cell_ff <= res_cell_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ld_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ld_rsp) begin
         rsp_data_ff <= {{(RSP_DATA_W - ROW_BITS_W - 1){1'b0}}, res_cell_ff, res_bits_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The sweep never writes the row it is fetching
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (wr_addr != rd_addr))
      else $error("sweep write collides with sweep read");

   // A clear leaves every row invalid
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tdata[CMD_W-1:0] == CMD_CLEAR)) |=> (vld_ff == '0))
      else $error("clear left a valid row");

   // Memory writes happen only in the sweep or the toggle update
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_RUN) || (state_ff == ST_LAST) || (state_ff == ST_MOD)))
      else $error("grid write outside a writing state");

   // A result appears only when the controller hands one over
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("result raised outside reply");

   // An accepted item always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted item not started");

endmodule

`default_nettype wire

@@ hdl/lge_row_rule.sv @@
// Next-generation logic for one grid row from its three-row window.
`default_nettype none

module lge_row_rule
   import lge_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  wire  [GRID_SIZE-1:0] up_row,
   input  wire  [GRID_SIZE-1:0] mid_row,
   input  wire  [GRID_SIZE-1:0] dn_row,
   output logic [GRID_SIZE-1:0] nxt_row
);

   // Count wrapped neighbors and apply the survive/birth rule per column
   for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
      localparam int LC = (c == 0) ? GRID_SIZE - 1 : c - 1;
      localparam int RC = (c == GRID_SIZE - 1) ? 0 : c + 1;
      logic [3:0] cnt;

      assign cnt = 4'(up_row[LC]) + 4'(up_row[c]) + 4'(up_row[RC])
                 + 4'(mid_row[LC]) + 4'(mid_row[RC])
                 + 4'(dn_row[LC]) + 4'(dn_row[c]) + 4'(dn_row[RC]);

      assign nxt_row[c] = (cnt == BIRTH_COUNT) || (mid_row[c] && (cnt == KEEP_COUNT));
   end

endmodule

`default_nettype wire
